FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/olar_pkg.sv
`default_nettype none

package olar_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Held count at capacity, seen through the 6-bit entry_count field
    localparam logic [CNT_W+5:0] FULL_EXT   = (CNT_W + 6)'(CAPACITY);
    localparam logic [5:0]       FULL_COUNT = FULL_EXT[5:0];

    typedef enum logic [1:0] {
        REQ_APPEND        = 2'd0,
        REQ_REMOVE_VALUE  = 2'd1,
        REQ_REMOVE_PARITY = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
        logic                     parity;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed_value;
        logic [5:0]               entry_count;
    } result_t;

    typedef struct packed {
        logic cmp_en;
        logic by_parity;
        logic parity;
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Inclusive prefix OR from index 0 upward, log-depth
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] p;
        p = v;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            p = p | (p << s);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: design/olar_cell.sv
`default_nettype none

module olar_cell (
    input  wire logic                               clk,
    input  wire olar_pkg::cell_ctrl_t               ctrl,
    input  wire logic                               valid,
    input  wire logic signed [olar_pkg::DATA_W-1:0] key,
    input  wire logic signed [olar_pkg::DATA_W-1:0] neighbor,
    output logic signed [olar_pkg::DATA_W-1:0]      value,
    output logic                                    hit
);

    logic signed [olar_pkg::DATA_W-1:0] value_reg;
    logic                               hit_reg;
    logic                               match;

    always_comb
    begin
        if (ctrl.by_parity)
        begin
            match = (value_reg[0] == ctrl.parity);
        end
        else
        begin
            match = (value_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            hit_reg <= valid & match;
        end
        // load writes an append; shift pulls the right neighbor in to close a gap
        if (ctrl.load)
        begin
            value_reg <= key;
        end
        else if (ctrl.shift)
        begin
            value_reg <= neighbor;
        end
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

FILE: design/ordered_list_append_remove.sv
`default_nettype none

// Channel   | Ports                      | Handshake
// ----------+----------------------------+------------------------------------
// request   | start, busy, req           | taken at a rising edge with start=1, busy=0
// result    | done, result               | done high one cycle; receiver cannot stall
//
// Each request passes through compare, select and apply after acceptance:
// compare in every cell, pick the first hit and build the per-cell
// commands, apply the shift or load; the result strobe follows in the
// cycle after apply, while the block already takes the next request. The
// compare, select and apply steps run in sequence over the row of cells.
// rst_n clears the count and the control; cell contents are not reset
// and only cells below the count are ever compared or returned.

module ordered_list_append_remove (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire olar_pkg::req_t    req,
    output logic                   done,
    output olar_pkg::result_t      result
);

    localparam int CAP = olar_pkg::CAPACITY;
    localparam int CW  = olar_pkg::CNT_W;
    localparam int DW  = olar_pkg::DATA_W;

    olar_pkg::state_t   state_reg, state_next;
    olar_pkg::req_t     req_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pend_reg, pend_next;
    logic [CAP-1:0]     shift_reg, shift_next;
    logic [CAP-1:0]     load_reg, load_next;
    logic [CAP-1:0]     first_reg, first_next;
    logic [1:0]         status_reg, status_next;
    olar_pkg::result_t  result_reg, result_next;
    logic               done_reg, done_next;

    logic               accept;
    logic               full;
    logic [CAP-1:0]     hit;
    logic [CAP-1:0]     upto;
    logic [CAP-1:0]     valid;
    logic signed [DW-1:0] vals [CAP];
    logic signed [DW-1:0] removed;
    logic [CW+5:0]      pend_ext;

    assign accept = start & ~busy;
    assign full   = (count_reg == CW'(CAP));

    // Prefix of hits: every cell at or past the first hit shifts left
    assign upto = olar_pkg::prefix_or(hit);

    // Row of cells; cell i hands its entry to cell i-1
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        olar_pkg::cell_ctrl_t            ctrl;
        logic signed [DW-1:0]            nb;

        assign valid[i] = (CW'(i) < count_reg);

        always_comb
        begin
            ctrl.cmp_en    = (state_reg == olar_pkg::S_CMP);
            ctrl.by_parity = (req_reg.req_type == olar_pkg::REQ_REMOVE_PARITY);
            ctrl.parity    = req_reg.parity;
            ctrl.shift     = shift_reg[i] & (state_reg == olar_pkg::S_APPLY);
            ctrl.load      = load_reg[i] & (state_reg == olar_pkg::S_APPLY);
        end

        if (i == CAP - 1)
        begin : g_last
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = vals[i+1];
        end

        olar_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .valid    (valid[i]),
            .key      (req_reg.value),
            .neighbor (nb),
            .value    (vals[i]),
            .hit      (hit[i])
        );
    end

    // Gather the removed entry through the one-hot first-hit mask
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < CAP; i++)
        begin
            removed = removed | (first_reg[i] ? vals[i] : '0);
        end
    end

    assign pend_ext = {6'b0, pend_reg};

    // Sequencer: next state, per-cell commands and the result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        shift_next  = shift_reg;
        load_next   = load_reg;
        first_next  = first_reg;
        status_next = status_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        busy        = (state_reg != olar_pkg::S_IDLE);

        case (state_reg)
            olar_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = olar_pkg::S_CMP;
                end
            end
            olar_pkg::S_CMP:
            begin
                // cells register their hits at this edge
                state_next = olar_pkg::S_SEL;
            end
            olar_pkg::S_SEL:
            begin
                shift_next  = '0;
                load_next   = '0;
                first_next  = '0;
                pend_next   = count_reg;
                status_next = olar_pkg::ST_DONE;
                case (req_reg.req_type)
                    olar_pkg::REQ_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = olar_pkg::ST_FULL;
                        end
                        else
                        begin
                            for (int i = 0; i < CAP; i++)
                            begin
                                load_next[i] = (CW'(i) == count_reg);
                            end
                            pend_next = count_reg + CW'(1);
                        end
                    end
                    olar_pkg::REQ_REMOVE_VALUE,
                    olar_pkg::REQ_REMOVE_PARITY:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = olar_pkg::ST_EMPTY;
                        end
                        else if (|hit)
                        begin
                            shift_next = upto;
                            first_next = upto & ~(upto << 1);
                            pend_next  = count_reg - CW'(1);
                        end
                        else
                        begin
                            status_next = olar_pkg::ST_NOMATCH;
                        end
                    end
                    default:
                    begin
                        // unknown request: leave the list alone
                        status_next = olar_pkg::ST_DONE;
                    end
                endcase
                state_next = olar_pkg::S_APPLY;
            end
            olar_pkg::S_APPLY:
            begin
                // cells shift or load at this edge; capture the result
                count_next                = pend_reg;
                result_next.status        = status_reg;
                result_next.removed_value = removed;
                result_next.entry_count   = pend_ext[5:0];
                done_next                 = 1'b1;
                state_next                = olar_pkg::S_IDLE;
            end
            default:
            begin
                state_next = olar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olar_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            shift_reg  <= '0;
            load_reg   <= '0;
            first_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            load_reg   <= load_next;
            first_reg  <= first_next;
            done_reg   <= done_next;
        end
    end

    // Payload: hold the request, the pending count, status and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        pend_reg   <= pend_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: design/olar_checker.sv
`default_nettype none

`include "assert_macros.svh"

module olar_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire olar_pkg::result_t result
);

    // An accepted request makes the block busy right after
    `ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but busy stays low")

    // The result strobe comes only once the block is free again
    `ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")

    // One result per request: the strobe is never held high
    `ASSERT_NXT(a_done_single, done, !done, "result strobe held for two cycles")

    // Full is only reported at capacity, empty only at zero
    `ASSERT_IMP(a_full_count, done && result.status == olar_pkg::ST_FULL,
        result.entry_count == olar_pkg::FULL_COUNT, "full reported below capacity")
    `ASSERT_IMP(a_empty_count, done && result.status == olar_pkg::ST_EMPTY,
        result.entry_count == 6'd0 && result.removed_value == 0, "empty with entries")

endmodule

bind ordered_list_append_remove olar_checker u_olar_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

FILE: test/tb.sv
module tb;
    import olar_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_REQUESTS = 1750;
    // Leave generous slack after the last result
    localparam int DRAIN_CYCLES    = 20;
    // At least 1768 requests and the gaps between bursts, taken many times over
    localparam int CYCLE_LIMIT     = 200000;

    // The package names only the three real request kinds; the fourth code is ignored
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // Random traffic mix: lean toward filling, toward draining, or neither
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    // Shadow copy of the list. Every accepted request updates it and queues the
    // reply the block owes; replies come back strictly in request order.
    class list_shadow;
        logic signed [DATA_W-1:0] held[$];
        result_t pending[$];
        int errors = 0;
        int checked = 0;
        int tally[4] = '{0, 0, 0, 0};
        int full_seen = 0;

        function void note_request(req_t r);
            result_t want;
            int hit_at;
            want = '0;
            hit_at = -1;
            case (r.req_type)
                REQ_APPEND:
                begin
                    if (held.size() >= CAPACITY)
                        want.status = ST_FULL;
                    else
                        held.push_back(r.value);
                end
                REQ_REMOVE_VALUE, REQ_REMOVE_PARITY:
                begin
                    if (held.size() == 0)
                        want.status = ST_EMPTY;
                    else
                    begin
                        // First hit from the head wins
                        for (int i = 0; i < held.size() && hit_at < 0; i++)
                        begin
                            if (r.req_type == REQ_REMOVE_VALUE ? held[i] == r.value
                                                               : held[i][0] == r.parity)
                                hit_at = i;
                        end
                        if (hit_at < 0)
                            want.status = ST_NOMATCH;
                        else
                        begin
                            want.status = ST_DONE;
                            want.removed_value = held[hit_at];
                            held.delete(hit_at);
                        end
                    end
                end
                default:
                    want.status = ST_DONE;
            endcase
            want.entry_count = 6'(held.size());
            pending.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no request pending: status %0d removed_value %0d",
                       got.status, got.removed_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            tally[want.status]++;
            if (want.entry_count == FULL_COUNT)
                full_seen++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.removed_value !== want.removed_value)
            begin
                $error("removed_value: expected %0d, got %0d",
                       want.removed_value, got.removed_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    req_t    req   = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      cycle_count = 0;

    list_shadow shadow = new();

    ordered_list_append_remove dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watch both channels at every rising edge. Values read here are the ones
    // settled before the edge, so a request counts exactly when the block
    // latches it, and a result exactly in its strobe cycle.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (start && !busy)
                shadow.note_request(req);
            if (done === 1'b1)
                shadow.check_result(result);
        end
    end

    // Hard stop in case the block hangs or never answers
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    // Present one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge that accepted the request.
    task automatic issue(input req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic issue_fields(input logic [1:0] kind, input logic signed [DATA_W-1:0] v,
                                input logic par);
        req_t r;
        r.req_type = kind;
        r.value    = v;
        r.parity   = par;
        issue(r);
    endtask

    // Mostly small values so that equal-value removals find hits, with full-range
    // words and both extremes mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DATA_W'($signed($urandom_range(0, 15)) - 8);
            5, 6, 7:       return $urandom;
            8:             return {1'b1, {(DATA_W-1){1'b0}}};
            default:       return {1'b0, {(DATA_W-1){1'b1}}};
        endcase
    endfunction

    function automatic req_t make_request(input int mix);
        req_t r;
        int roll;
        int append_pct;
        r.value    = pick_value();
        r.parity   = 1'($urandom_range(0, 1));
        append_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
        roll       = $urandom_range(0, 99);
        if (roll < 3)
            r.req_type = REQ_UNKNOWN;
        else if (roll < 3 + append_pct)
            r.req_type = REQ_APPEND;
        else if ($urandom_range(0, 1) == 1)
        begin
            r.req_type = REQ_REMOVE_VALUE;
            // Aim most value removals at something actually held
            if (shadow.held.size() > 0 && $urandom_range(0, 3) != 0)
                r.value = shadow.held[$urandom_range(0, shadow.held.size() - 1)];
        end
        else
            r.req_type = REQ_REMOVE_PARITY;
        return r;
    endfunction

    initial
    begin
        int   made;
        int   burst_left;
        int   mix;
        int   mix_left;
        req_t r;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list removals and the ignored code first, then the
        // extremes and negatives, hits at head, middle and tail, a miss of each
        // kind, and finally removing the only entry so the list empties again.
        issue_fields(REQ_REMOVE_VALUE,  32'sd5, 1'b0);
        issue_fields(REQ_REMOVE_PARITY, 32'sd0, 1'b0);
        issue_fields(REQ_UNKNOWN,       32'sd7, 1'b1);
        issue_fields(REQ_APPEND,        {1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        issue_fields(REQ_APPEND,        {1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
        issue_fields(REQ_APPEND,        -32'sd1, 1'b0);
        issue_fields(REQ_APPEND,        32'sd0, 1'b1);
        issue_fields(REQ_APPEND,        -32'sd3, 1'b0);
        issue_fields(REQ_APPEND,        -32'sd4, 1'b1);
        issue_fields(REQ_REMOVE_VALUE,  32'sd12345, 1'b0);
        issue_fields(REQ_REMOVE_PARITY, 32'sd0, 1'b1);
        issue_fields(REQ_REMOVE_VALUE,  -32'sd4, 1'b0);
        issue_fields(REQ_REMOVE_VALUE,  {1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
        issue_fields(REQ_REMOVE_PARITY, -32'sd1, 1'b0);
        issue_fields(REQ_UNKNOWN,       -32'sd1, 1'b0);
        issue_fields(REQ_REMOVE_PARITY, 32'sd2, 1'b1);
        issue_fields(REQ_REMOVE_PARITY, 32'sd9, 1'b0);
        issue_fields(REQ_REMOVE_VALUE,  -32'sd3, 1'b1);

        // Random: phases that fill, drain or hold the list steady, so it keeps
        // swinging between empty and full. The sender runs in bursts; between
        // bursts it mostly drops start and puts noise on the request bus.
        made       = 0;
        mix        = MIX_FILL;
        mix_left   = $urandom_range(40, 60);
        burst_left = $urandom_range(1, 30);
        while (made < RANDOM_REQUESTS)
        begin
            if (mix_left == 0)
            begin
                mix      = $urandom_range(MIX_FILL, MIX_EVEN);
                mix_left = $urandom_range(10, 60);
            end
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    req   <= {2'($urandom), DATA_W'($urandom), 1'($urandom)};
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                burst_left = $urandom_range(1, 30);
            end
            r = make_request(mix);
            issue(r);
            if (r.req_type != REQ_UNKNOWN)
                made++;
            mix_left--;
            burst_left--;
        end
        start <= 1'b0;

        // Drain: wait for every owed reply, then give the block time to show
        // any stray strobe.
        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d replies: %0d done, %0d full, %0d empty, %0d no match.",
                 shadow.checked, shadow.tally[ST_DONE], shadow.tally[ST_FULL],
                 shadow.tally[ST_EMPTY], shadow.tally[ST_NOMATCH]);
        $display("List stood at capacity after %0d requests; %0d mismatches.",
                 shadow.full_seen, shadow.errors);
        if (shadow.errors == 0 && shadow.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
